// File: design/mipmap_chain_box_filter_macros.svh
// assertion helpers
`ifndef MIPMAP_CHAIN_BOX_FILTER_MACROS_SVH
`define MIPMAP_CHAIN_BOX_FILTER_MACROS_SVH
`define MCBF_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define MCBF_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// File: design/mcbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mcbf_pkg;
  localparam int MAX_DIM_LOG2 = 12;
  localparam int CHANNELS = 4;
  localparam int LEVELS = MAX_DIM_LOG2 + 1;
  localparam int STORE_DEPTH = 2 << MAX_DIM_LOG2;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int LV_W = 4;
  localparam int POS_W = 12;
  localparam logic [0:0] REG_WIDTH = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EMIT, ST_READ, ST_WAIT, ST_AVG
  } state_t;

  typedef struct packed {
    logic [LV_W-1:0]  level;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [7:0]       out_red;
    logic [7:0]       out_green;
    logic [7:0]       out_blue;
    logic [7:0]       out_alpha;
    logic             last_of_run;
    logic             image_done;
  } result_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic       index;
    logic [3:0] data;
  } cfg_t;

  function automatic logic [31:0] avg4(logic [31:0] a, logic [31:0] b,
                                       logic [31:0] c, logic [31:0] d);
    logic [31:0] res;
    logic [9:0] s;
    res = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      s = {2'b0, a[8*ch +: 8]} + {2'b0, b[8*ch +: 8]} + {2'b0, c[8*ch +: 8]}
        + {2'b0, d[8*ch +: 8]};
      res[8*ch +: 8] = s[9:2];
    end
    return res;
  endfunction
endpackage
`default_nettype wire

// File: design/mcbf_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mcbf_if #(type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/mipmap_chain_box_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming mipmap chain generator, 2x2 truncated box filter on RGBA8.
// Channels: pix_in (sink) takes base pixels in raster order; res_out
// (source) gives results: the base pixel as level 0, then each finished
// 2x2 block average at the next level, up to the 1x1 top (image_done).
// last_of_run marks the final result of one request. cfg (sink) writes
// width_log2 (index 0) or height_log2 (index 1); a write restarts the image.
// Exponents above 12 saturate to 12.
// Sequencing: one request runs through a sequencer that handles one level at
// a time: each result is emitted, and for each level whose block completes
// the line store is addressed, read twice with registered reads and averaged,
// or only averaged when that level is a single row. The averaging unit is
// shared by all levels and the line store has a single read port.
// The block takes no request while one is in flight; a stalled receiver
// holds the result register and the sequencer waits.
// Reset: counters and holds clear, registers return to 8/8; the line store
// has no reset and every entry is written before it is read.
module mipmap_chain_box_filter (
  input wire logic clk,
  input wire logic rst,
  mcbf_if.sink    pix_in,
  mcbf_if.source  res_out,
  mcbf_if.sink    cfg
);
  localparam int AW = mcbf_pkg::ADDR_W;
  localparam int PW = mcbf_pkg::POS_W;
  localparam int LW = mcbf_pkg::LV_W;

  mcbf_pkg::state_t state, state_next;
  logic [3:0] width_log2, height_log2;
  logic [PW-1:0] col_cnt [mcbf_pkg::LEVELS];
  logic [PW-1:0] row_cnt [mcbf_pkg::LEVELS];
  logic [31:0] left_hold [mcbf_pkg::LEVELS];
  logic [31:0] store [mcbf_pkg::STORE_DEPTH];
  logic [31:0] pix, rd_tl, rd_tr;
  logic [LW-1:0] lv;
  logic rd_sel;
  logic [AW-1:0] rd_addr;
  logic [31:0] rd_data;
  mcbf_pkg::result_t res;
  logic res_valid;

  // saturated exponents
  logic [LW-1:0] wl, hl, top, lw, lh;
  assign wl = (width_log2 > 4'(mcbf_pkg::MAX_DIM_LOG2)) ?
              4'(mcbf_pkg::MAX_DIM_LOG2) : width_log2;
  assign hl = (height_log2 > 4'(mcbf_pkg::MAX_DIM_LOG2)) ?
              4'(mcbf_pkg::MAX_DIM_LOG2) : height_log2;
  assign top = (wl > hl) ? wl : hl;
  assign lw = (wl > lv) ? wl - lv : '0;
  assign lh = (hl > lv) ? hl - lv : '0;

  logic [PW-1:0] c, r;
  assign c = col_cnt[lv];
  assign r = row_cnt[lv];
  logic wide, tall, col_end, row_end, at_top, store_even, hold_even;
  assign wide = lw != '0;
  assign tall = lh != '0;
  assign col_end = ({1'b0, c} + 13'd1) >= (13'd1 << lw);
  assign row_end = ({1'b0, r} + 13'd1) >= (13'd1 << lh);
  assign at_top = lv >= top;
  assign store_even = tall && !r[0];
  assign hold_even = wide && !c[0];

  // level slot base: STORE_DEPTH - (STORE_DEPTH >> lv)
  logic [AW:0] slot_off;
  assign slot_off = (AW+1)'(mcbf_pkg::STORE_DEPTH) - ((AW+1)'(mcbf_pkg::STORE_DEPTH) >> lv);
  // column of the block being averaged; the live count has moved on by then
  logic [PW-1:0] c_hold;
  logic [AW-1:0] addr_c, addr_l, addr_h;
  assign addr_c = slot_off[AW-1:0] + AW'(c);
  assign addr_h = slot_off[AW-1:0] + AW'(c_hold);
  assign addr_l = slot_off[AW-1:0] + AW'(wide ? c_hold - PW'(1) : c_hold);

  logic emit_done, finish;
  assign emit_done = (state == mcbf_pkg::ST_EMIT) && (!res_valid || res_out.ready);
  assign finish = at_top || store_even || hold_even;

  always_comb begin
    state_next = state;
    unique case (state)
      mcbf_pkg::ST_IDLE: if (pix_in.valid && pix_in.ready) state_next = mcbf_pkg::ST_EMIT;
      mcbf_pkg::ST_EMIT: if (emit_done) begin
        if (finish) state_next = mcbf_pkg::ST_IDLE;
        else if (tall) state_next = mcbf_pkg::ST_READ;
        else state_next = mcbf_pkg::ST_AVG;
      end
      mcbf_pkg::ST_READ: state_next = mcbf_pkg::ST_WAIT;
      mcbf_pkg::ST_WAIT: if (rd_sel) state_next = mcbf_pkg::ST_AVG;
      mcbf_pkg::ST_AVG: state_next = mcbf_pkg::ST_EMIT;
      default: state_next = mcbf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pix_in.ready = (state == mcbf_pkg::ST_IDLE) && !cfg.valid;
    cfg.ready = (state == mcbf_pkg::ST_IDLE);
    rd_addr = (state == mcbf_pkg::ST_READ) ? addr_l : addr_h;
  end

  always_ff @(posedge clk) begin
    rd_data <= store[rd_addr];
    if (emit_done && !at_top && store_even) store[addr_c] <= pix;
  end

  logic [31:0] left_px;
  assign left_px = wide ? left_hold[lv] : pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcbf_pkg::ST_IDLE;
      width_log2 <= 4'd8;
      height_log2 <= 4'd8;
      res_valid <= 1'b0;
      lv <= '0;
      rd_sel <= 1'b0;
      c_hold <= '0;
      for (int i = 0; i < mcbf_pkg::LEVELS; i++) begin
        col_cnt[i] <= '0;
        row_cnt[i] <= '0;
        left_hold[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (res_valid && res_out.ready) res_valid <= 1'b0;
      if (cfg.valid && cfg.ready) begin
        if (cfg.data.index == mcbf_pkg::REG_WIDTH) width_log2 <= cfg.data.data;
        else height_log2 <= cfg.data.data;
        for (int i = 0; i < mcbf_pkg::LEVELS; i++) begin
          col_cnt[i] <= '0;
          row_cnt[i] <= '0;
        end
      end
      if (pix_in.valid && pix_in.ready) begin
        pix <= {pix_in.data.alpha, pix_in.data.blue, pix_in.data.green, pix_in.data.red};
        lv <= '0;
      end
      if (emit_done) begin
        res_valid <= 1'b1;
        res.level <= lv;
        res.col <= c;
        res.row <= r;
        res.out_red <= pix[7:0];
        res.out_green <= pix[15:8];
        res.out_blue <= pix[23:16];
        res.out_alpha <= pix[31:24];
        res.last_of_run <= finish;
        res.image_done <= at_top;
        c_hold <= c;
        if (col_end) begin
          col_cnt[lv] <= '0;
          row_cnt[lv] <= row_end ? '0 : r + PW'(1);
        end else begin
          col_cnt[lv] <= c + PW'(1);
        end
        if (!at_top && !store_even && hold_even) left_hold[lv] <= pix;
        rd_sel <= 1'b0;
      end
      if (state == mcbf_pkg::ST_WAIT) begin
        if (!rd_sel) rd_tl <= rd_data;
        else rd_tr <= rd_data;
        rd_sel <= 1'b1;
      end
      if (state == mcbf_pkg::ST_AVG) begin
        pix <= tall ? mcbf_pkg::avg4(rd_tl, rd_tr, left_px, pix)
                    : mcbf_pkg::avg4(left_px, pix, left_px, pix);
        lv <= lv + LW'(1);
      end
    end
  end

  assign res_out.valid = res_valid;
  assign res_out.data = res;

`include "mipmap_chain_box_filter_macros.svh"
  `MCBF_ASSERT_IMPL(a_no_accept_busy, state != mcbf_pkg::ST_IDLE, !pix_in.ready)
  `MCBF_ASSERT_IMPL(a_level_range, res_valid, res.level <= 4'(mcbf_pkg::MAX_DIM_LOG2))
  `MCBF_ASSERT_NEXT(a_stall_hold, res_valid && !res_out.ready, res_valid && $stable(res))
  `MCBF_ASSERT_IMPL(a_done_last, res_valid && res.image_done, res.last_of_run)
endmodule
`default_nettype wire

// File: tb/tb_mipmap_chain_box_filter.sv
`timescale 1ns / 1ps
module tb_mipmap_chain_box_filter;

  class mip_scoreboard;
    mcbf_pkg::result_t exp_q[$];
    logic [31:0] row_store[mcbf_pkg::STORE_DEPTH];
    logic [31:0] left_hold[mcbf_pkg::LEVELS];
    int          col_cnt[mcbf_pkg::LEVELS];
    int          row_cnt[mcbf_pkg::LEVELS];
    int          w_exp;
    int          h_exp;
    int          errors;

    function new();
      foreach (left_hold[i]) left_hold[i] = '0;
      clear_pos();
      w_exp = 8;
      h_exp = 8;
      errors = 0;
    endfunction

    function void clear_pos();
      foreach (col_cnt[i]) begin
        col_cnt[i] = 0;
        row_cnt[i] = 0;
      end
    endfunction

    function void set_reg(logic idx, logic [3:0] val);
      if (idx == mcbf_pkg::REG_WIDTH) w_exp = int'(val);
      else h_exp = int'(val);
      clear_pos();
    endfunction

    function int pending();
      return exp_q.size();
    endfunction

    function logic [31:0] box_avg(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                  logic [31:0] d);
      logic [31:0] res;
      logic [9:0]  s;
      for (int ch = 0; ch < mcbf_pkg::CHANNELS; ch++) begin
        s = {2'b0, a[8*ch +: 8]} + {2'b0, b[8*ch +: 8]} + {2'b0, c[8*ch +: 8]}
          + {2'b0, d[8*ch +: 8]};
        res[8*ch +: 8] = s[9:2];
      end
      return res;
    endfunction

    // walk up the chain while 2x2 blocks complete
    function void note_pixel(mcbf_pkg::pixel_t px);
      int wl, hl, top, lv, lw, lh, c, r, off;
      logic [31:0] p, left, tl, tr;
      mcbf_pkg::result_t res;
      wl = (w_exp > mcbf_pkg::MAX_DIM_LOG2) ? mcbf_pkg::MAX_DIM_LOG2 : w_exp;
      hl = (h_exp > mcbf_pkg::MAX_DIM_LOG2) ? mcbf_pkg::MAX_DIM_LOG2 : h_exp;
      top = (wl > hl) ? wl : hl;
      p = {px.alpha, px.blue, px.green, px.red};
      lv = 0;
      while (1) begin
        lw = (wl > lv) ? wl - lv : 0;
        lh = (hl > lv) ? hl - lv : 0;
        c = col_cnt[lv];
        r = row_cnt[lv];
        res.level = 4'(lv);
        res.col = 12'(c);
        res.row = 12'(r);
        res.out_red = p[7:0];
        res.out_green = p[15:8];
        res.out_blue = p[23:16];
        res.out_alpha = p[31:24];
        res.last_of_run = 1'b0;
        res.image_done = (lv == top);
        exp_q.push_back(res);
        if (c + 1 >= (1 << lw)) begin
          col_cnt[lv] = 0;
          row_cnt[lv] = (r + 1 >= (1 << lh)) ? 0 : r + 1;
        end else begin
          col_cnt[lv] = c + 1;
        end
        if (lv >= top) break;
        off = mcbf_pkg::STORE_DEPTH - (mcbf_pkg::STORE_DEPTH >> lv);
        if (lh > 0 && r % 2 == 0) begin
          row_store[(off + c) % mcbf_pkg::STORE_DEPTH] = p;
          break;
        end
        if (lw > 0 && c % 2 == 0) begin
          left_hold[lv] = p;
          break;
        end
        left = (lw > 0) ? left_hold[lv] : p;
        if (lh > 0) begin
          tl = row_store[(off + ((lw > 0) ? c - 1 : c)) % mcbf_pkg::STORE_DEPTH];
          tr = row_store[(off + c) % mcbf_pkg::STORE_DEPTH];
        end else begin
          tl = left;
          tr = p;
        end
        p = box_avg(tl, tr, left, p);
        lv++;
      end
      exp_q[exp_q.size() - 1].last_of_run = 1'b1;
    endfunction

    function void cmp(string fname, int e, int g);
      if (e != g) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, e, g);
        errors++;
      end
    endfunction

    function void check(mcbf_pkg::result_t got);
      mcbf_pkg::result_t e;
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, got);
        errors++;
        return;
      end
      e = exp_q.pop_front();
      cmp("level", e.level, got.level);
      cmp("col", e.col, got.col);
      cmp("row", e.row, got.row);
      cmp("out_red", e.out_red, got.out_red);
      cmp("out_green", e.out_green, got.out_green);
      cmp("out_blue", e.out_blue, got.out_blue);
      cmp("out_alpha", e.out_alpha, got.out_alpha);
      cmp("last_of_run", e.last_of_run, got.last_of_run);
      cmp("image_done", e.image_done, got.image_done);
    endfunction
  endclass

  logic clk;
  logic rst;

  mcbf_if #(mcbf_pkg::pixel_t)  pix_in (clk);
  mcbf_if #(mcbf_pkg::result_t) res_out (clk);
  mcbf_if #(mcbf_pkg::cfg_t)    cfg (clk);

  mipmap_chain_box_filter i_dut (
    .clk(clk),
    .rst(rst),
    .pix_in(pix_in),
    .res_out(res_out),
    .cfg(cfg)
  );

  mip_scoreboard     sb;
  logic              calm;
  logic              out_fire;
  mcbf_pkg::result_t out_snap;
  int                rx_wait;
  int                n_pix;
  int                n_res;
  int                n_img;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("tb_mipmap_chain_box_filter: done, errors");
    $finish;
  end

  // sample the handshake mid-cycle, act on it at the next rising edge
  always @(negedge clk) begin
    out_fire = res_out.valid && res_out.ready && !rst;
    out_snap = res_out.data;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_out.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_fire) begin
        sb.check(out_snap);
        n_res++;
        rx_wait = calm ? 0 : $urandom_range(0, 8);
      end
      if (rx_wait > 0) begin
        res_out.ready <= 1'b0;
        rx_wait--;
      end else begin
        res_out.ready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(mcbf_pkg::pixel_t px);
    int gap;
    logic r;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.data <= px;
    do begin
      @(negedge clk);
      r = pix_in.ready;
      @(posedge clk);
    end while (!r);
    sb.note_pixel(px);
    n_pix++;
  endtask

  // drop the pixel request and drain everything still expected
  task automatic settle();
    pix_in.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    logic r;
    cfg.valid <= 1'b1;
    cfg.data <= '{index: idx, data: val};
    do begin
      @(negedge clk);
      r = cfg.ready;
      @(posedge clk);
    end while (!r);
    cfg.valid <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_size(logic [3:0] w, logic [3:0] h);
    settle();
    write_reg(mcbf_pkg::REG_WIDTH, w);
    write_reg(mcbf_pkg::REG_HEIGHT, h);
  endtask

  initial begin
    int wl, hl, full, cnt, n_rand;
    sb = new();
    calm = 1'b0;
    n_pix = 0;
    n_res = 0;
    n_img = 0;
    rst = 1'b1;
    pix_in.valid = 1'b0;
    pix_in.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default 256x256: first row only, level 0 results
    send_pixel(32'h00000000);
    send_pixel(32'hffffffff);
    send_pixel(32'h80808080);
    send_pixel(32'h7f01fe10);
    // 1x1 base: each pixel is the top level
    set_size(4'd0, 4'd0);
    send_pixel(32'hffffffff);
    send_pixel(32'h00000000);
    send_pixel(mcbf_pkg::pixel_t'($urandom));
    // 2x2, all-max then near-max to catch carry loss
    set_size(4'd1, 4'd1);
    repeat (4) send_pixel(32'hffffffff);
    send_pixel(32'hffffffff);
    send_pixel(32'hfffefdff);
    send_pixel(32'h01ff00fe);
    // restart mid-image on a register write
    settle();
    write_reg(mcbf_pkg::REG_HEIGHT, 4'd1);
    repeat (4) send_pixel(mcbf_pkg::pixel_t'($urandom));
    // oversized width saturates, single row cascades by width pairs
    set_size(4'd15, 4'd0);
    repeat (8) send_pixel(mcbf_pkg::pixel_t'($urandom));
    set_size(4'd12, 4'd13);
    repeat (3) send_pixel(mcbf_pkg::pixel_t'($urandom));

    n_rand = 0;
    while (n_rand < 190) begin
      wl = $urandom_range(0, 3);
      hl = $urandom_range(0, 3);
      set_size(4'(wl), 4'(hl));
      calm = ($urandom_range(0, 3) == 0);
      full = 1 << (wl + hl);
      repeat ($urandom_range(1, 2)) begin
        cnt = ($urandom_range(0, 4) == 0 && full > 1) ? $urandom_range(1, full - 1) : full;
        if (cnt > 190 - n_rand) cnt = 190 - n_rand;
        if (cnt == full) n_img++;
        repeat (cnt) send_pixel(mcbf_pkg::pixel_t'($urandom));
        n_rand += cnt;
      end
      calm = 1'b0;
    end

    settle();
    $display("covered %0d pixels, %0d results, %0d full random images", n_pix, n_res,
             n_img);
    $display("sizes 1x1 to 8x8 random, saturated 4096-wide row, mid-image restart");
    if (sb.errors == 0) begin
      $display("tb_mipmap_chain_box_filter: done, clean");
    end else begin
      $display("tb_mipmap_chain_box_filter: done, errors");
    end
    $finish;
  end
endmodule
